// File: rtl/art_pkg.sv
// Shared constants, codes and control structs for the acknowledgement retransmission tracker.
package art_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_BOOT     = 2'd2;

  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd200;
  localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd3;
  localparam logic [31:0] LOCAL_BOOT_RST     = 32'd0;

  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_ACK    = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [3:0] KIND_SENT_TRACKED = 4'd0;
  localparam logic [3:0] KIND_SENT_BCAST   = 4'd1;
  localparam logic [3:0] KIND_FULL         = 4'd2;
  localparam logic [3:0] KIND_CONFLICT     = 4'd3;
  localparam logic [3:0] KIND_DELIVERED    = 4'd4;
  localparam logic [3:0] KIND_ACK_UNMATCH  = 4'd5;
  localparam logic [3:0] KIND_RETRY        = 4'd6;
  localparam logic [3:0] KIND_FAIL_TOPO    = 4'd7;
  localparam logic [3:0] KIND_FAIL_TIMEOUT = 4'd8;
  localparam logic [3:0] KIND_DONE         = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;
    logic stop;
  } dp_sts_t;

endpackage

// File: rtl/art_ctrl.sv
// Controller state machine that sequences the slot scan for each command.
module art_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output art_pkg::dp_cmd_t dp_cmd,
  input  art_pkg::dp_sts_t dp_sts
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [art_pkg::IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    dp_cmd.load = 1'b0;
    dp_cmd.scan = 1'b0;
    dp_cmd.fin  = 1'b0;
    dp_cmd.idx  = idx_r;
    busy        = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          dp_cmd.load = 1'b1;
          idx_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        // A single-result command ends on its first matching slot.
        if (dp_sts.hit && dp_sts.stop) begin
          state_nxt = S_IDLE;
        end else if (idx_r == art_pkg::IDX_W'(art_pkg::SLOTS - 1)) begin
          state_nxt = S_FINAL;
        end else begin
          idx_nxt = idx_r + art_pkg::IDX_W'(1);
        end
      end
      S_FINAL: begin
        dp_cmd.fin = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/art_dp.sv
// Datapath: configuration, request latch, slot table, per-slot checks and result register.
module art_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [art_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [art_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [1:0]                       in_cmd,
  input  logic [31:0]                      in_now_ms,
  input  logic [31:0]                      in_msg_number,
  input  logic [31:0]                      in_msg_boot,
  input  logic [63:0]                      in_peer_node,
  input  logic [15:0]                      in_service_num,
  input  logic [31:0]                      in_topology_num,
  input  logic                             in_topology_conflict,
  input  art_pkg::dp_cmd_t                 dp_cmd,
  output art_pkg::dp_sts_t                 dp_sts,
  output logic                             out_valid,
  output logic [3:0]                       out_kind,
  output logic [2:0]                       out_slot,
  output logic [31:0]                      out_number,
  output logic [63:0]                      out_peer,
  output logic [15:0]                      out_service,
  output logic                             out_last
);

  // Configuration registers.
  logic [31:0] interval_r;
  logic [7:0]  limit_r;
  logic [31:0] local_boot_r;

  // Latched request.
  logic [1:0]  cmd_r;
  logic [31:0] now_r;
  logic [31:0] num_r;
  logic [31:0] boot_r;
  logic [63:0] peer_r;
  logic [15:0] svc_r;
  logic [31:0] topo_r;
  logic        conflict_r;

  logic [31:0] next_number_r, next_number_nxt;

  // Slot table.
  logic [art_pkg::SLOTS-1:0] ent_valid_r;
  logic [31:0] ent_number_r  [art_pkg::SLOTS];
  logic [31:0] ent_boot_r    [art_pkg::SLOTS];
  logic [63:0] ent_dest_r    [art_pkg::SLOTS];
  logic [15:0] ent_service_r [art_pkg::SLOTS];
  logic [31:0] ent_topo_r    [art_pkg::SLOTS];
  logic [7:0]  ent_retries_r [art_pkg::SLOTS];
  logic [31:0] ent_sent_r    [art_pkg::SLOTS];

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_kind_r, out_kind_nxt;
  logic [2:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_number_r, out_number_nxt;
  logic [63:0] out_peer_r, out_peer_nxt;
  logic [15:0] out_service_r, out_service_nxt;
  logic        out_last_r, out_last_nxt;

  // Entry at the current scan position.
  logic        cur_valid;
  logic [31:0] cur_number;
  logic [31:0] cur_boot;
  logic [63:0] cur_dest;
  logic [15:0] cur_service;
  logic [31:0] cur_topo;
  logic [7:0]  cur_retries;
  logic [31:0] cur_sent;
  logic [31:0] idx_ext;
  logic [31:0] elapsed;
  logic        due;
  logic        hit_raw;
  logic        take;

  logic        wr_new;
  logic        wr_clear;
  logic        wr_retry;

  assign cur_valid   = ent_valid_r[dp_cmd.idx];
  assign cur_number  = ent_number_r[dp_cmd.idx];
  assign cur_boot    = ent_boot_r[dp_cmd.idx];
  assign cur_dest    = ent_dest_r[dp_cmd.idx];
  assign cur_service = ent_service_r[dp_cmd.idx];
  assign cur_topo    = ent_topo_r[dp_cmd.idx];
  assign cur_retries = ent_retries_r[dp_cmd.idx];
  assign cur_sent    = ent_sent_r[dp_cmd.idx];
  assign idx_ext     = 32'(dp_cmd.idx);

  // Elapsed time wraps modulo 2^32, so a plain subtraction gives it.
  assign elapsed = now_r - cur_sent;
  assign due     = cur_valid && (elapsed >= interval_r);

  always_comb begin
    case (cmd_r)
      art_pkg::CMD_SEND: begin
        hit_raw = !cur_valid && !conflict_r && (peer_r != 64'd0);
      end
      art_pkg::CMD_ACK: begin
        hit_raw = cur_valid && (cur_number == num_r) && (cur_boot == boot_r) &&
                  (cur_dest == peer_r) && (cur_service == svc_r);
      end
      art_pkg::CMD_TICK: begin
        hit_raw = due;
      end
      art_pkg::CMD_CANCEL: begin
        hit_raw = cur_valid && (cur_number == num_r);
      end
      default: begin
        hit_raw = 1'b0;
      end
    endcase
  end

  assign take        = dp_cmd.scan && hit_raw;
  assign dp_sts.hit  = take;
  assign dp_sts.stop = (cmd_r != art_pkg::CMD_TICK);

  // Next message number; it skips zero when it wraps.
  always_comb begin
    next_number_nxt = next_number_r;
    if (dp_cmd.load && (in_cmd == art_pkg::CMD_SEND) && !in_topology_conflict) begin
      next_number_nxt = next_number_r + 32'd1;
      if (next_number_nxt == 32'd0) begin
        next_number_nxt = 32'd1;
      end
    end
  end

  always_comb begin
    wr_new          = 1'b0;
    wr_clear        = 1'b0;
    wr_retry        = 1'b0;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = art_pkg::KIND_DONE;
    out_slot_nxt    = 3'd0;
    out_number_nxt  = 32'd0;
    out_peer_nxt    = 64'd0;
    out_service_nxt = 16'd0;
    out_last_nxt    = 1'b1;
    if (take) begin
      out_valid_nxt   = 1'b1;
      out_slot_nxt    = idx_ext[2:0];
      out_number_nxt  = cur_number;
      out_peer_nxt    = cur_dest;
      out_service_nxt = cur_service;
      case (cmd_r)
        art_pkg::CMD_SEND: begin
          wr_new          = 1'b1;
          out_kind_nxt    = art_pkg::KIND_SENT_TRACKED;
          out_number_nxt  = next_number_r;
          out_peer_nxt    = peer_r;
          out_service_nxt = svc_r;
        end
        art_pkg::CMD_ACK: begin
          wr_clear     = 1'b1;
          out_kind_nxt = art_pkg::KIND_DELIVERED;
        end
        art_pkg::CMD_TICK: begin
          out_last_nxt = 1'b0;
          if (cur_topo != topo_r) begin
            wr_clear     = 1'b1;
            out_kind_nxt = art_pkg::KIND_FAIL_TOPO;
          end else if (cur_retries >= limit_r) begin
            wr_clear     = 1'b1;
            out_kind_nxt = art_pkg::KIND_FAIL_TIMEOUT;
          end else begin
            wr_retry     = 1'b1;
            out_kind_nxt = art_pkg::KIND_RETRY;
          end
        end
        art_pkg::CMD_CANCEL: begin
          wr_clear     = 1'b1;
          out_kind_nxt = art_pkg::KIND_DONE;
        end
        default: begin
          out_kind_nxt = art_pkg::KIND_DONE;
        end
      endcase
    end else if (dp_cmd.fin) begin
      // The scan found nothing to report that ends the command.
      out_valid_nxt = 1'b1;
      case (cmd_r)
        art_pkg::CMD_SEND: begin
          if (conflict_r) begin
            out_kind_nxt = art_pkg::KIND_CONFLICT;
          end else if (peer_r == 64'd0) begin
            out_kind_nxt    = art_pkg::KIND_SENT_BCAST;
            out_number_nxt  = next_number_r;
            out_service_nxt = svc_r;
          end else begin
            out_kind_nxt    = art_pkg::KIND_FULL;
            out_number_nxt  = next_number_r;
            out_peer_nxt    = peer_r;
            out_service_nxt = svc_r;
          end
        end
        art_pkg::CMD_ACK: begin
          out_kind_nxt = art_pkg::KIND_ACK_UNMATCH;
        end
        default: begin
          out_kind_nxt = art_pkg::KIND_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= art_pkg::RETRY_INTERVAL_RST;
      limit_r       <= art_pkg::RETRY_LIMIT_RST;
      local_boot_r  <= art_pkg::LOCAL_BOOT_RST;
      next_number_r <= 32'd0;
      ent_valid_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          art_pkg::CFG_RETRY_INTERVAL: interval_r   <= cfg_wdata[31:0];
          art_pkg::CFG_RETRY_LIMIT:    limit_r      <= cfg_wdata[7:0];
          art_pkg::CFG_LOCAL_BOOT:     local_boot_r <= cfg_wdata[31:0];
          default: begin
          end
        endcase
      end
      next_number_r <= next_number_nxt;
      out_valid_r   <= out_valid_nxt;
      if (wr_new) begin
        ent_valid_r[dp_cmd.idx] <= 1'b1;
      end else if (wr_clear) begin
        ent_valid_r[dp_cmd.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r      <= in_cmd;
      now_r      <= in_now_ms;
      num_r      <= in_msg_number;
      boot_r     <= in_msg_boot;
      peer_r     <= in_peer_node;
      svc_r      <= in_service_num;
      topo_r     <= in_topology_num;
      conflict_r <= in_topology_conflict;
    end
    if (wr_new) begin
      ent_number_r[dp_cmd.idx]  <= next_number_r;
      ent_boot_r[dp_cmd.idx]    <= local_boot_r;
      ent_dest_r[dp_cmd.idx]    <= peer_r;
      ent_service_r[dp_cmd.idx] <= svc_r;
      ent_topo_r[dp_cmd.idx]    <= topo_r;
      ent_retries_r[dp_cmd.idx] <= 8'd0;
      ent_sent_r[dp_cmd.idx]    <= now_r;
    end else if (wr_retry) begin
      ent_retries_r[dp_cmd.idx] <= cur_retries + 8'd1;
      ent_sent_r[dp_cmd.idx]    <= now_r;
    end
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_number_r  <= out_number_nxt;
    out_peer_r    <= out_peer_nxt;
    out_service_r <= out_service_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot    = out_slot_r;
  assign out_number  = out_number_r;
  assign out_peer    = out_peer_r;
  assign out_service = out_service_r;
  assign out_last    = out_last_r;

endmodule

// File: rtl/ack_retransmit_tracker.sv
// Top level of the acknowledgement retransmission tracker: controller plus datapath.
//
//   channel   handshake          payload
//   in_       start / busy       in_cmd .. in_topology_conflict
//   out_      out_valid strobe   out_kind .. out_last
//   cfg_      cfg_we             cfg_index, cfg_wdata
//
// A command is loaded, then the slots are scanned in order (SLOTS at most),
// then a closing step follows when no slot ended it.
// The slot scan reads one table entry per cycle.
// Each result is on the out_ ports for one cycle, the last one flagged by out_last.
// Reset clears the controller, the slot valid bits, the message counter and out_valid, and loads the config defaults.
// The receiver cannot stall; busy stays high until the last result is registered.
module ack_retransmit_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic [31:0]                    in_now_ms,
  input  logic [31:0]                    in_msg_number,
  input  logic [31:0]                    in_msg_boot,
  input  logic [63:0]                    in_peer_node,
  input  logic [15:0]                    in_service_num,
  input  logic [31:0]                    in_topology_num,
  input  logic                           in_topology_conflict,
  output logic                           out_valid,
  output logic [3:0]                     out_kind,
  output logic [2:0]                     out_slot,
  output logic [31:0]                    out_number,
  output logic [63:0]                    out_peer,
  output logic [15:0]                    out_service,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [art_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  art_pkg::dp_cmd_t dp_cmd;
  art_pkg::dp_sts_t dp_sts;

  art_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .dp_cmd (dp_cmd),
    .dp_sts (dp_sts)
  );

  art_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_cmd               (in_cmd),
    .in_now_ms            (in_now_ms),
    .in_msg_number        (in_msg_number),
    .in_msg_boot          (in_msg_boot),
    .in_peer_node         (in_peer_node),
    .in_service_num       (in_service_num),
    .in_topology_num      (in_topology_num),
    .in_topology_conflict (in_topology_conflict),
    .dp_cmd               (dp_cmd),
    .dp_sts               (dp_sts),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_slot             (out_slot),
    .out_number           (out_number),
    .out_peer             (out_peer),
    .out_service          (out_service),
    .out_last             (out_last)
  );

endmodule

// File: rtl/art_checker.sv
// Port-level checker for the tracker and the bind that attaches it.
module art_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [3:0]  out_kind,
  input logic [2:0]  out_slot,
  input logic [31:0] out_number,
  input logic [63:0] out_peer,
  input logic        out_last
);

  // An accepted command keeps the block busy on the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted command");

  // The closing transfer of a command is never followed directly by another result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result right after the closing transfer");

  // Intermediate tick results only appear while the scan is still running.
  a_mid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("intermediate result while idle");

  // Going idle always coincides with the closing transfer.
  a_idle_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_valid && out_last))
    else $error("block went idle without a closing transfer");

  // Sends refused for a topology conflict and unmatched acks carry no entry.
  a_empty_results: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == art_pkg::KIND_CONFLICT ||
                   out_kind == art_pkg::KIND_ACK_UNMATCH))
    |-> (out_slot == 3'd0 && out_number == 32'd0 && out_peer == 64'd0))
    else $error("empty result carries entry fields");

endmodule

bind ack_retransmit_tracker art_checker u_art_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_kind   (out_kind),
  .out_slot   (out_slot),
  .out_number (out_number),
  .out_peer   (out_peer),
  .out_last   (out_last)
);
